// File: hdl/assert_macros.svh
// concurrent assertion helpers, clocked on clk with synchronous active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: hdl/mbdeq_pkg.sv
package mbdeq_pkg;

  localparam int BANDS_DEF       = 4;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int REG_BANDS       = 4;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_W           = 64;
  localparam int MUL_A_W         = 33;
  localparam int MUL_B_W         = 28;
  localparam int PROD_W          = MUL_A_W + MUL_B_W;
  localparam int ACC_W           = 64;
  localparam int Y_W             = 32;
  localparam int LIN_W           = 27;
  localparam int DEEP_W          = 13;

  localparam logic [1:0] REG_GRP_FILTER = 2'd0;
  localparam logic [1:0] REG_GRP_DYN    = 2'd1;

  localparam int DB16_FLOOR      = -3200;
  localparam int GAIN_CEIL       = 1024;
  localparam int REDUCTION_FLOOR = -4096;
  localparam int DB_SCALE        = 6165;
  localparam int EXP_SCALE       = 1361;
  localparam int UNITY_Q15       = 32768;
  localparam int NORM_STEPS      = 5;

  localparam logic [5:0] LOG2_TAB [32] = '{
    6'd0,  6'd3,  6'd6,  6'd8,  6'd11, 6'd13, 6'd16, 6'd18,
    6'd21, 6'd23, 6'd25, 6'd27, 6'd29, 6'd31, 6'd34, 6'd35,
    6'd37, 6'd39, 6'd41, 6'd43, 6'd45, 6'd47, 6'd48, 6'd50,
    6'd52, 6'd53, 6'd55, 6'd56, 6'd58, 6'd60, 6'd61, 6'd63
  };

  localparam logic [15:0] EXP2_TAB [32] = '{
    16'd32768, 16'd33486, 16'd34219, 16'd34968, 16'd35734, 16'd36516, 16'd37316, 16'd38133,
    16'd38968, 16'd39821, 16'd40693, 16'd41584, 16'd42495, 16'd43425, 16'd44376, 16'd45348,
    16'd46341, 16'd47356, 16'd48393, 16'd49452, 16'd50535, 16'd51642, 16'd52773, 16'd53928,
    16'd55109, 16'd56316, 16'd57549, 16'd58809, 16'd60097, 16'd61413, 16'd62757, 16'd64132
  };

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_BQ0, S_BQ1, S_BQ2, S_BQ3, S_ENV0, S_ENV1, S_NORM, S_LOG,
    S_DB, S_GR0, S_GR1, S_FF, S_TOT, S_LIN0, S_LIN1, S_COR0, S_COR1, S_FINAL
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_BQ_M0, OP_BQ_M1, OP_BQ_M2, OP_BQ_END, OP_ENV_M, OP_ENV_END,
    OP_NORM, OP_LOG_M, OP_DB, OP_GR_M, OP_GR, OP_FF_M, OP_TOT, OP_LIN_M, OP_LIN,
    OP_COR_M, OP_COR, OP_FINAL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       side_pass;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic band_en;
    logic side_mode;
    logic out_busy;
  } status_t;

endpackage

// File: hdl/multiband_dynamic_eq.sv
// per enabled band: biquad (again for sidechain), envelope, normalise, log, gain, correction
// one shared 33x28 multiplier steps bands serially
// the next item is accepted once the previous result sits in the output register
// reset: synchronous active-low rst_n clears control, config, filter history and envelopes
module multiband_dynamic_eq #(
  parameter int BANDS       = mbdeq_pkg::BANDS_DEF,
  parameter int SAMPLE_BITS = mbdeq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_main_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_side_sample,
  input  logic                                in_use_sidechain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic signed [mbdeq_pkg::DEEP_W-1:0] out_deepest_reduction,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbdeq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbdeq_pkg::CFG_W-1:0]         cfg_data
);

  localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;

  mbdeq_pkg::cmd_t    cmd;
  mbdeq_pkg::status_t sts;
  logic [BAND_W-1:0]  band;

  assign cfg_ready = 1'b1;

  mbdeq_ctrl #(
    .BANDS  (BANDS),
    .BAND_W (BAND_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .band     (band)
  );

  mbdeq_dp #(
    .BANDS       (BANDS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .BAND_W      (BAND_W)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .band                  (band),
    .sts                   (sts),
    .in_main_sample        (in_main_sample),
    .in_side_sample        (in_side_sample),
    .in_use_sidechain      (in_use_sidechain),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_sample            (out_sample),
    .out_deepest_reduction (out_deepest_reduction)
  );

endmodule

// File: hdl/mbdeq_ctrl.sv
`include "assert_macros.svh"

module mbdeq_ctrl #(
  parameter int BANDS  = mbdeq_pkg::BANDS_DEF,
  parameter int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbdeq_pkg::status_t  sts,
  output mbdeq_pkg::cmd_t     cmd,
  output logic [BAND_W-1:0]   band
);

  localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BANDS - 1);
  localparam logic [2:0]        LAST_STEP = 3'(mbdeq_pkg::NORM_STEPS - 1);

  mbdeq_pkg::state_t state_r, state_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic              pass_r, pass_nxt;
  logic [2:0]        step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbdeq_pkg::S_IDLE;
      band_r  <= '0;
      pass_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      band_r  <= band_nxt;
      pass_r  <= pass_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    band_nxt  = band_r;
    pass_nxt  = pass_r;
    step_nxt  = step_r;
    case (state_r)
      mbdeq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = mbdeq_pkg::S_CHECK;
          band_nxt  = '0;
        end
      end
      mbdeq_pkg::S_CHECK: begin
        if (sts.band_en) begin
          state_nxt = mbdeq_pkg::S_BQ0;
          pass_nxt  = 1'b0;
        end else if (band_r == LAST_BAND) begin
          state_nxt = mbdeq_pkg::S_FINAL;
        end else begin
          band_nxt = band_r + 1'b1;
        end
      end
      mbdeq_pkg::S_BQ0: state_nxt = mbdeq_pkg::S_BQ1;
      mbdeq_pkg::S_BQ1: state_nxt = mbdeq_pkg::S_BQ2;
      mbdeq_pkg::S_BQ2: state_nxt = mbdeq_pkg::S_BQ3;
      mbdeq_pkg::S_BQ3: begin
        if (!pass_r && sts.side_mode) begin
          state_nxt = mbdeq_pkg::S_BQ0;
          pass_nxt  = 1'b1;
        end else begin
          state_nxt = mbdeq_pkg::S_ENV0;
        end
      end
      mbdeq_pkg::S_ENV0: state_nxt = mbdeq_pkg::S_ENV1;
      mbdeq_pkg::S_ENV1: begin
        state_nxt = mbdeq_pkg::S_NORM;
        step_nxt  = '0;
      end
      mbdeq_pkg::S_NORM: begin
        if (step_r == LAST_STEP) begin
          state_nxt = mbdeq_pkg::S_LOG;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      mbdeq_pkg::S_LOG:  state_nxt = mbdeq_pkg::S_DB;
      mbdeq_pkg::S_DB:   state_nxt = mbdeq_pkg::S_GR0;
      mbdeq_pkg::S_GR0:  state_nxt = mbdeq_pkg::S_GR1;
      mbdeq_pkg::S_GR1:  state_nxt = mbdeq_pkg::S_FF;
      mbdeq_pkg::S_FF:   state_nxt = mbdeq_pkg::S_TOT;
      mbdeq_pkg::S_TOT:  state_nxt = mbdeq_pkg::S_LIN0;
      mbdeq_pkg::S_LIN0: state_nxt = mbdeq_pkg::S_LIN1;
      mbdeq_pkg::S_LIN1: state_nxt = mbdeq_pkg::S_COR0;
      mbdeq_pkg::S_COR0: state_nxt = mbdeq_pkg::S_COR1;
      mbdeq_pkg::S_COR1: begin
        if (band_r == LAST_BAND) begin
          state_nxt = mbdeq_pkg::S_FINAL;
        end else begin
          state_nxt = mbdeq_pkg::S_CHECK;
          band_nxt  = band_r + 1'b1;
        end
      end
      mbdeq_pkg::S_FINAL: begin
        if (!sts.out_busy) begin
          state_nxt = mbdeq_pkg::S_IDLE;
        end
      end
      default: state_nxt = mbdeq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.side_pass = pass_r;
    cmd.step      = step_r;
    in_stall      = (state_r != mbdeq_pkg::S_IDLE);
    case (state_r)
      mbdeq_pkg::S_IDLE:  cmd.op = in_valid ? mbdeq_pkg::OP_LOAD : mbdeq_pkg::OP_NOP;
      mbdeq_pkg::S_BQ0:   cmd.op = mbdeq_pkg::OP_BQ_M0;
      mbdeq_pkg::S_BQ1:   cmd.op = mbdeq_pkg::OP_BQ_M1;
      mbdeq_pkg::S_BQ2:   cmd.op = mbdeq_pkg::OP_BQ_M2;
      mbdeq_pkg::S_BQ3:   cmd.op = mbdeq_pkg::OP_BQ_END;
      mbdeq_pkg::S_ENV0:  cmd.op = mbdeq_pkg::OP_ENV_M;
      mbdeq_pkg::S_ENV1:  cmd.op = mbdeq_pkg::OP_ENV_END;
      mbdeq_pkg::S_NORM:  cmd.op = mbdeq_pkg::OP_NORM;
      mbdeq_pkg::S_LOG:   cmd.op = mbdeq_pkg::OP_LOG_M;
      mbdeq_pkg::S_DB:    cmd.op = mbdeq_pkg::OP_DB;
      mbdeq_pkg::S_GR0:   cmd.op = mbdeq_pkg::OP_GR_M;
      mbdeq_pkg::S_GR1:   cmd.op = mbdeq_pkg::OP_GR;
      mbdeq_pkg::S_FF:    cmd.op = mbdeq_pkg::OP_FF_M;
      mbdeq_pkg::S_TOT:   cmd.op = mbdeq_pkg::OP_TOT;
      mbdeq_pkg::S_LIN0:  cmd.op = mbdeq_pkg::OP_LIN_M;
      mbdeq_pkg::S_LIN1:  cmd.op = mbdeq_pkg::OP_LIN;
      mbdeq_pkg::S_COR0:  cmd.op = mbdeq_pkg::OP_COR_M;
      mbdeq_pkg::S_COR1:  cmd.op = mbdeq_pkg::OP_COR;
      mbdeq_pkg::S_FINAL: cmd.op = sts.out_busy ? mbdeq_pkg::OP_NOP : mbdeq_pkg::OP_FINAL;
      default:            cmd.op = mbdeq_pkg::OP_NOP;
    endcase
  end

  assign band = band_r;

  `ASSERT_NEXT(a_accept_starts, state_r == mbdeq_pkg::S_IDLE && in_valid, state_r == mbdeq_pkg::S_CHECK && band_r == '0, "accepted item did not start band sweep")
  `ASSERT_NEXT(a_final_holds, state_r == mbdeq_pkg::S_FINAL && sts.out_busy, state_r == mbdeq_pkg::S_FINAL, "result overwrote a pending output")
  `ASSERT_ALWAYS(a_side_pass_mode, !(pass_r && state_r == mbdeq_pkg::S_BQ0) || sts.side_mode, "sidechain pass in normal mode")

endmodule

// File: hdl/mbdeq_dp.sv
module mbdeq_dp #(
  parameter int BANDS       = mbdeq_pkg::BANDS_DEF,
  parameter int SAMPLE_BITS = mbdeq_pkg::SAMPLE_BITS_DEF,
  parameter int BAND_W      = (BANDS > 1) ? $clog2(BANDS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mbdeq_pkg::cmd_t                     cmd,
  input  logic [BAND_W-1:0]                   band,
  output mbdeq_pkg::status_t                  sts,
  input  logic signed [SAMPLE_BITS-1:0]       in_main_sample,
  input  logic signed [SAMPLE_BITS-1:0]       in_side_sample,
  input  logic                                in_use_sidechain,
  input  logic                                cfg_we,
  input  logic [mbdeq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbdeq_pkg::CFG_W-1:0]         cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic signed [mbdeq_pkg::DEEP_W-1:0] out_deepest_reduction
);

  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = mbdeq_pkg::PROD_W;
  localparam int AW   = mbdeq_pkg::ACC_W;
  localparam int YW   = mbdeq_pkg::Y_W;
  localparam int LW   = mbdeq_pkg::LIN_W;
  localparam int CBW  = $clog2(mbdeq_pkg::REG_BANDS);

  logic [mbdeq_pkg::CFG_W-1:0] flt_r [mbdeq_pkg::REG_BANDS];
  logic [mbdeq_pkg::CFG_W-1:0] dyn_r [mbdeq_pkg::REG_BANDS];

  logic signed [SB-1:0] mxh0_r [BANDS];
  logic signed [SB-1:0] mxh1_r [BANDS];
  logic signed [YW-1:0] myh0_r [BANDS];
  logic signed [YW-1:0] myh1_r [BANDS];
  logic signed [SB-1:0] sxh0_r [BANDS];
  logic signed [SB-1:0] sxh1_r [BANDS];
  logic signed [YW-1:0] syh0_r [BANDS];
  logic signed [YW-1:0] syh1_r [BANDS];
  logic [SB-1:0]        env_r  [BANDS];

  logic signed [SB-1:0]  x_r, xs_r;
  logic                  side_r;
  logic signed [PW-1:0]  p_r;
  logic signed [AW-1:0]  acc_r;
  logic signed [YW-1:0]  bp_r, det_r;
  logic [SB-1:0]         mag_r;
  logic [31:0]           n_r;
  logic [4:0]            pcnt_r;
  logic                  zero_r;
  logic signed [13:0]    db_r;
  logic                  under_r;
  logic signed [15:0]    gr_r, deep_r, total_r;
  logic [LW-1:0]         lin_r;
  logic signed [AW-1:0]  corr_r;
  logic                  out_valid_r;
  logic signed [SB-1:0]  out_sample_r;
  logic signed [mbdeq_pkg::DEEP_W-1:0] out_deep_r;

  logic [mbdeq_pkg::CFG_W-1:0] flt, dyn;
  logic signed [19:0]          b0, a1, a2;
  logic [11:0]                 att, rel;
  logic signed [11:0]          thr, gain;
  logic [7:0]                  slope, ffac;
  logic [CBW-1:0]              cband;

  logic signed [mbdeq_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mbdeq_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]                 prod;

  logic signed [SB-1:0]  xsel, xh1;
  logic signed [YW-1:0]  y1, y2;
  logic signed [SB:0]    dx;
  logic signed [AW-1:0]  accf, rnd;
  logic signed [YW-1:0]  ynew;
  logic [YW-1:0]         absd;
  logic [SB-1:0]         mag;
  logic [32:0]           emax;
  logic signed [SB:0]    ediff;
  logic signed [PW-1:0]  esum;
  logic [SB-1:0]         enew;
  logic [5:0]            nk;
  logic signed [13:0]    lval;
  logic signed [PW-1:0]  dbw;
  logic signed [14:0]    gdiff;
  logic signed [PW-1:0]  grw, gr2w;
  logic signed [15:0]    grn;
  logic signed [15:0]    tot;
  logic signed [PW-1:0]  e5w;
  logic signed [15:0]    e5, ip, nip;
  logic [15:0]           mant;
  logic [LW-1:0]         lin;
  logic signed [AW-1:0]  resw, smax, smin;

  assign cband = CBW'(band);
  assign flt   = flt_r[cband];
  assign dyn   = dyn_r[cband];
  assign b0    = flt[19:0];
  assign a1    = flt[39:20];
  assign a2    = flt[59:40];
  assign att   = dyn[11:0];
  assign rel   = dyn[23:12];
  assign thr   = dyn[35:24];
  assign slope = dyn[43:36];
  assign gain  = dyn[55:44];
  assign ffac  = dyn[63:56];

  assign sts.band_en   = (flt[59:0] != '0);
  assign sts.side_mode = side_r;
  assign sts.out_busy  = out_valid_r && out_stall;

  always_comb begin
    xsel = cmd.side_pass ? xs_r : x_r;
    xh1  = cmd.side_pass ? sxh1_r[band] : mxh1_r[band];
    y1   = cmd.side_pass ? syh0_r[band] : myh0_r[band];
    y2   = cmd.side_pass ? syh1_r[band] : myh1_r[band];
    dx   = (SB + 1)'(xsel) - (SB + 1)'(xh1);
    accf = acc_r - AW'(p_r);
    rnd  = (accf + (AW'(1) <<< 17)) >>> 18;
    if (rnd > AW'(32'sh7fffffff)) begin
      ynew = 32'sh7fffffff;
    end else if (rnd < -AW'(33'sh080000000)) begin
      ynew = 32'sh80000000;
    end else begin
      ynew = rnd[YW-1:0];
    end
    absd  = det_r[YW-1] ? YW'(-det_r) : YW'(det_r);
    emax  = (33'd1 << SB) - 33'd1;
    mag   = ({1'b0, absd} > emax) ? emax[SB-1:0] : absd[SB-1:0];
    ediff = $signed({1'b0, env_r[band]}) - $signed({1'b0, mag});
    esum  = $signed(PW'(mag_r)) + (p_r >>> 12);
    enew  = esum[SB-1:0];
    nk    = 6'd16 >> cmd.step;
    lval  = $signed({2'b0, pcnt_r, 6'b0}) +
            $signed({8'b0, mbdeq_pkg::LOG2_TAB[n_r[30:26]]}) - 14'((SB - 1) * 64);
    dbw   = (p_r + PW'(2048)) >>> 12;
    gdiff = 15'(db_r) - 15'(thr);
    grw   = (p_r + PW'(128)) >>> 8;
    grn   = -$signed(grw[15:0]);
    gr2w  = side_r ? PW'(gr_r) : ((p_r + PW'(64)) >>> 7);
    tot   = 16'(gain) + gr2w[15:0];
    e5w   = (p_r + PW'(2048)) >>> 12;
    e5    = e5w[15:0];
    ip    = e5 >>> 5;
    nip   = -ip;
    mant  = mbdeq_pkg::EXP2_TAB[e5[4:0]];
    if (!ip[15]) begin
      lin = LW'(mant) << ip[4:0];
    end else if (nip >= 16'sd17) begin
      lin = '0;
    end else begin
      lin = LW'(mant >> nip[4:0]);
    end
    smax = (AW'(1) <<< (SB - 1)) - AW'(1);
    smin = -(AW'(1) <<< (SB - 1));
    resw = AW'(x_r) + ((corr_r + AW'(16384)) >>> 15);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      mbdeq_pkg::OP_BQ_M0: begin
        mul_a = mbdeq_pkg::MUL_A_W'(dx);
        mul_b = mbdeq_pkg::MUL_B_W'(b0);
      end
      mbdeq_pkg::OP_BQ_M1: begin
        mul_a = mbdeq_pkg::MUL_A_W'(y1);
        mul_b = mbdeq_pkg::MUL_B_W'(a1);
      end
      mbdeq_pkg::OP_BQ_M2: begin
        mul_a = mbdeq_pkg::MUL_A_W'(y2);
        mul_b = mbdeq_pkg::MUL_B_W'(a2);
      end
      mbdeq_pkg::OP_ENV_M: begin
        mul_a = mbdeq_pkg::MUL_A_W'(ediff);
        mul_b = mbdeq_pkg::MUL_B_W'((mag > env_r[band]) ? att : rel);
      end
      mbdeq_pkg::OP_LOG_M: begin
        mul_a = mbdeq_pkg::MUL_A_W'(lval);
        mul_b = mbdeq_pkg::MUL_B_W'(mbdeq_pkg::DB_SCALE);
      end
      mbdeq_pkg::OP_GR_M: begin
        mul_a = mbdeq_pkg::MUL_A_W'(gdiff);
        mul_b = mbdeq_pkg::MUL_B_W'(slope);
      end
      mbdeq_pkg::OP_FF_M: begin
        mul_a = mbdeq_pkg::MUL_A_W'(gr_r);
        mul_b = mbdeq_pkg::MUL_B_W'(ffac);
      end
      mbdeq_pkg::OP_LIN_M: begin
        mul_a = mbdeq_pkg::MUL_A_W'(total_r);
        mul_b = mbdeq_pkg::MUL_B_W'(mbdeq_pkg::EXP_SCALE);
      end
      mbdeq_pkg::OP_COR_M: begin
        mul_a = mbdeq_pkg::MUL_A_W'(bp_r);
        mul_b = $signed({1'b0, lin_r}) - mbdeq_pkg::MUL_B_W'(mbdeq_pkg::UNITY_Q15);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // configuration, filter history and envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mbdeq_pkg::REG_BANDS; i++) begin
        flt_r[i] <= '0;
        dyn_r[i] <= '0;
      end
      for (int i = 0; i < BANDS; i++) begin
        mxh0_r[i] <= '0;
        mxh1_r[i] <= '0;
        myh0_r[i] <= '0;
        myh1_r[i] <= '0;
        sxh0_r[i] <= '0;
        sxh1_r[i] <= '0;
        syh0_r[i] <= '0;
        syh1_r[i] <= '0;
        env_r[i]  <= '0;
      end
    end else begin
      if (cfg_we && cfg_index[3:2] == mbdeq_pkg::REG_GRP_FILTER) begin
        flt_r[cfg_index[1:0]] <= cfg_data;
      end
      if (cfg_we && cfg_index[3:2] == mbdeq_pkg::REG_GRP_DYN) begin
        dyn_r[cfg_index[1:0]] <= cfg_data;
      end
      if (cmd.op == mbdeq_pkg::OP_BQ_END) begin
        if (cmd.side_pass) begin
          sxh1_r[band] <= sxh0_r[band];
          sxh0_r[band] <= xs_r;
          syh1_r[band] <= syh0_r[band];
          syh0_r[band] <= ynew;
        end else begin
          mxh1_r[band] <= mxh0_r[band];
          mxh0_r[band] <= x_r;
          myh1_r[band] <= myh0_r[band];
          myh0_r[band] <= ynew;
        end
      end
      if (cmd.op == mbdeq_pkg::OP_ENV_END) begin
        env_r[band] <= enew;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == mbdeq_pkg::OP_FINAL) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= prod;
    case (cmd.op)
      mbdeq_pkg::OP_LOAD: begin
        x_r    <= in_main_sample;
        xs_r   <= in_side_sample;
        side_r <= in_use_sidechain;
        corr_r <= '0;
        deep_r <= '0;
      end
      mbdeq_pkg::OP_BQ_M1: acc_r <= AW'(p_r);
      mbdeq_pkg::OP_BQ_M2: acc_r <= acc_r - AW'(p_r);
      mbdeq_pkg::OP_BQ_END: begin
        det_r <= ynew;
        if (!cmd.side_pass) begin
          bp_r <= ynew;
        end
      end
      mbdeq_pkg::OP_ENV_M: mag_r <= mag;
      mbdeq_pkg::OP_ENV_END: begin
        n_r    <= 32'(enew);
        pcnt_r <= 5'd31;
        zero_r <= (enew == '0);
      end
      mbdeq_pkg::OP_NORM: begin
        if ((n_r >> (6'd32 - nk)) == 32'd0) begin
          n_r    <= n_r << nk;
          pcnt_r <= pcnt_r - nk[4:0];
        end
      end
      mbdeq_pkg::OP_DB: begin
        if (zero_r || dbw < PW'(mbdeq_pkg::DB16_FLOOR)) begin
          db_r <= 14'(mbdeq_pkg::DB16_FLOOR);
        end else begin
          db_r <= dbw[13:0];
        end
      end
      mbdeq_pkg::OP_GR_M: under_r <= (db_r < 14'(thr));
      mbdeq_pkg::OP_GR: begin
        if (under_r) begin
          gr_r <= '0;
        end else begin
          gr_r <= grn;
          if (grn < deep_r) begin
            deep_r <= grn;
          end
        end
      end
      mbdeq_pkg::OP_TOT: total_r <= (tot > 16'(mbdeq_pkg::GAIN_CEIL)) ?
                                    16'(mbdeq_pkg::GAIN_CEIL) : tot;
      mbdeq_pkg::OP_LIN: lin_r <= lin;
      mbdeq_pkg::OP_COR: corr_r <= corr_r + AW'(p_r);
      mbdeq_pkg::OP_FINAL: begin
        if (resw > smax) begin
          out_sample_r <= smax[SB-1:0];
        end else if (resw < smin) begin
          out_sample_r <= smin[SB-1:0];
        end else begin
          out_sample_r <= resw[SB-1:0];
        end
        out_deep_r <= (deep_r < 16'(mbdeq_pkg::REDUCTION_FLOOR)) ?
                      mbdeq_pkg::DEEP_W'(mbdeq_pkg::REDUCTION_FLOOR) :
                      deep_r[mbdeq_pkg::DEEP_W-1:0];
      end
      default: ;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_sample            = out_sample_r;
  assign out_deepest_reduction = out_deep_r;

endmodule

// File: tb/sv/tb_multiband_dynamic_eq.sv
module tb_multiband_dynamic_eq;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 24;
  localparam int NB = 4;
  localparam int NUM_REGS = 8;
  localparam int DW = mbdeq_pkg::DEEP_W;
  localparam int IW = mbdeq_pkg::CFG_IDX_W;
  localparam longint ENV_MAX = (64'sd1 <<< SB) - 1;
  localparam longint SMP_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint SMP_MIN = -(64'sd1 <<< (SB - 1));
  localparam int DRAIN_CYCLES = 150;
  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    logic signed [SB-1:0] sample;
    logic signed [DW-1:0] deep;
  } eq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] in_main_sample = '0;
  logic signed [SB-1:0] in_side_sample = '0;
  logic in_use_sidechain = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] out_sample;
  logic signed [DW-1:0] out_deepest_reduction;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [mbdeq_pkg::CFG_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  longint cycle_count = 0;
  eq_result_t expected_results[$];

  logic [63:0] eq_regs [NUM_REGS];
  longint mx1 [NB], mx2 [NB], my1 [NB], my2 [NB];
  longint sx1 [NB], sx2 [NB], sy1 [NB], sy2 [NB];
  longint env_level [NB];

  multiband_dynamic_eq #(.BANDS(NB), .SAMPLE_BITS(SB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_main_sample(in_main_sample), .in_side_sample(in_side_sample),
    .in_use_sidechain(in_use_sidechain),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample(out_sample), .out_deepest_reduction(out_deepest_reduction),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic longint biquad(input longint x, b0, a1, a2,
                                    inout longint x1, x2, y1, y2);
    longint acc, y;
    acc = b0 * x - b0 * x2 - a1 * y1 - a2 * y2;
    y = (acc + (64'sd1 <<< 17)) >>> 18;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    x2 = x1;
    x1 = x;
    y2 = y1;
    y1 = y;
    return y;
  endfunction

  function automatic longint level_db16(input longint e);
    int p;
    int idx;
    longint l, db;
    if (e == 0) return mbdeq_pkg::DB16_FLOOR;
    p = 0;
    while ((e >> (p + 1)) != 0) p++;
    if (p >= 5) idx = int'((e >> (p - 5)) & 31);
    else idx = int'((e << (5 - p)) & 31);
    l = longint'(p) * 64 + longint'(mbdeq_pkg::LOG2_TAB[idx]) - longint'(SB - 1) * 64;
    db = (l * mbdeq_pkg::DB_SCALE + 2048) >>> 12;
    return (db < mbdeq_pkg::DB16_FLOOR) ? longint'(mbdeq_pkg::DB16_FLOOR) : db;
  endfunction

  function automatic longint gain_q15(input longint db16);
    longint e5, ip, mant;
    e5 = (db16 * mbdeq_pkg::EXP_SCALE + 2048) >>> 12;
    ip = e5 >>> 5;
    mant = longint'(mbdeq_pkg::EXP2_TAB[int'(e5 & 31)]);
    if (ip >= 0) return mant <<< ip;
    if (ip <= -17) return 0;
    return mant >>> (-ip);
  endfunction

  task automatic predict_eq(input logic signed [SB-1:0] ms, ss, input logic side);
    longint x, xs, bp, det, mag, c, db, thr, gr, gr2, total, lin, corr, deep, res;
    logic [63:0] f, d;
    eq_result_t r;
    x = longint'($signed(ms));
    xs = longint'($signed(ss));
    corr = 0;
    deep = 0;
    for (int b = 0; b < NB; b++) begin
      f = eq_regs[b];
      d = eq_regs[4 + b];
      if (f[59:0] == 0) continue;
      bp = biquad(x, longint'($signed(f[19:0])), longint'($signed(f[39:20])),
                  longint'($signed(f[59:40])), mx1[b], mx2[b], my1[b], my2[b]);
      if (side)
        det = biquad(xs, longint'($signed(f[19:0])), longint'($signed(f[39:20])),
                     longint'($signed(f[59:40])), sx1[b], sx2[b], sy1[b], sy2[b]);
      else
        det = bp;
      mag = (det < 0) ? -det : det;
      if (mag > ENV_MAX) mag = ENV_MAX;
      c = (mag > env_level[b]) ? longint'(d[11:0]) : longint'(d[23:12]);
      env_level[b] = (mag + ((c * (env_level[b] - mag)) >>> 12)) & ENV_MAX;
      db = level_db16(env_level[b]);
      thr = longint'($signed(d[35:24]));
      if (db < thr) gr = 0;
      else gr = -(((db - thr) * longint'(d[43:36]) + 128) >>> 8);
      if (gr < deep) deep = gr;
      gr2 = side ? gr : ((gr * longint'(d[63:56]) + 64) >>> 7);
      total = longint'($signed(d[55:44])) + gr2;
      if (total > mbdeq_pkg::GAIN_CEIL) total = mbdeq_pkg::GAIN_CEIL;
      lin = gain_q15(total);
      corr += bp * (lin - mbdeq_pkg::UNITY_Q15);
    end
    res = x + ((corr + 16384) >>> 15);
    if (res > SMP_MAX) res = SMP_MAX;
    if (res < SMP_MIN) res = SMP_MIN;
    if (deep < mbdeq_pkg::REDUCTION_FLOOR) deep = mbdeq_pkg::REDUCTION_FLOOR;
    r.sample = res[SB-1:0];
    r.deep = deep[DW-1:0];
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    eq_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item, sample %0d deepest %0d", $time,
                 out_sample, out_deepest_reduction);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_sample !== e.sample) begin
          $display("%0t: out_sample expected %0d actual %0d", $time, e.sample, out_sample);
          fail_count++;
        end
        if (out_deepest_reduction !== e.deep) begin
          $display("%0t: deepest_reduction expected %0d actual %0d", $time, e.deep,
                   out_deepest_reduction);
          fail_count++;
        end
      end
    end
  end

  task automatic send_item(input logic signed [SB-1:0] ms, ss, input logic side);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_main_sample <= ms;
    in_side_sample <= ss;
    in_use_sidechain <= side;
    do @(posedge clk); while (in_stall);
    predict_eq(ms, ss, side);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NUM_REGS) eq_regs[idx] = val;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pack_dyn(input logic [11:0] att, rel, thr,
                                           input logic [7:0] slope,
                                           input logic [11:0] gain, input logic [7:0] ff);
    return {ff, gain, slope, thr, rel, att};
  endfunction

  function automatic logic [63:0] bandpass_coefs();
    int a2, a1, b0;
    a2 = $urandom_range(259522, 209715);
    a1 = -int'($urandom_range(a2 + 262144 - 2000, 0));
    b0 = (262144 - a2) / 2;
    return {4'h0, a2[19:0], a1[19:0], b0[19:0]};
  endfunction

  function automatic logic [63:0] random_filter();
    int k;
    k = $urandom_range(19);
    if (k < 14) return bandpass_coefs();
    if (k < 16) return 64'h0;
    if (k < 17) return {4'($urandom_range(15, 1)), 60'h0};
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] random_dyn();
    logic [11:0] thr, gain;
    thr = ($urandom_range(3) == 0) ? 12'($urandom) : 12'(-int'($urandom_range(1600, 0)));
    gain = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(384) - 192);
    return pack_dyn(12'($urandom), 12'($urandom), thr, 8'($urandom), gain, 8'($urandom));
  endfunction

  function automatic logic signed [SB-1:0] random_sample();
    logic signed [SB-1:0] v;
    v = SB'($urandom);
    case ($urandom_range(3))
      0: return v;
      1: return v >>> $urandom_range(16, 1);
      2: return $urandom_range(1) ? SB'(SMP_MAX) : SB'(SMP_MIN);
      default: return v >>> 18;
    endcase
  endfunction

  task automatic test_bypass();
    send_item(SB'(SMP_MAX), SB'(SMP_MIN), 1'b0);
    send_item(SB'(SMP_MIN), SB'(SMP_MAX), 1'b1);
    send_item('0, '0, 1'b0);
    send_item('1, '1, 1'b1);
    wait_idle();
  endtask

  task automatic test_extremes();
    write_reg(IW'(0), bandpass_coefs());
    write_reg(IW'(4), pack_dyn(12'd0, 12'hFFF, 12'h800, 8'hFF, 12'h7FF, 8'hFF));
    write_reg(IW'(1), bandpass_coefs());
    write_reg(IW'(5), pack_dyn(12'hFFF, 12'd0, 12'd0, 8'd0, 12'h800, 8'd0));
    write_reg(IW'(2), 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(IW'(6), 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(IW'(3), 64'hF000_0000_0000_0000);
    write_reg(IW'(7), random_dyn());
    for (int i = NUM_REGS; i < 16; i++) write_reg(IW'(i), {$urandom, $urandom});
    for (int i = 0; i < 20; i++) begin
      send_item((i % 2) ? SB'(SMP_MAX) : SB'(SMP_MIN),
                (i % 3) ? SB'(SMP_MIN) : SB'(SMP_MAX), 1'((i / 4) % 2));
    end
    send_item('0, '0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_phases();
    int modes_idle [6] = '{0, 82, 0, 7, 82, 0};
    int modes_stall [6] = '{0, 0, 82, 7, 82, 0};
    logic side;
    for (int ph = 0; ph < 6; ph++) begin
      for (int b = 0; b < NB; b++) begin
        write_reg(IW'(b), random_filter());
        write_reg(IW'(4 + b), random_dyn());
      end
      send_idle_pct = modes_idle[ph];
      recv_stall_pct = modes_stall[ph];
      side = 1'($urandom);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(15) == 0) side = ~side;
        send_item(random_sample(), random_sample(), side);
        if (i == ITEMS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          while (expected_results.size() > 0) @(posedge clk);
        end
      end
      wait_idle();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) eq_regs[i] = '0;
    for (int b = 0; b < NB; b++) begin
      mx1[b] = 0; mx2[b] = 0; my1[b] = 0; my2[b] = 0;
      sx1[b] = 0; sx2[b] = 0; sy1[b] = 0; sy2[b] = 0;
      env_level[b] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bypass();
    test_extremes();
    test_random_phases();
    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
